FILE: hdl/mgap_pkg.sv
package mgap_pkg;

  // Field width of every sample and result
  localparam int DATA_WIDTH  = 16;
  // Extra fraction bits on the CORDIC vector
  localparam int GUARD_BITS  = 14;
  // Angle accumulator scale: 2^31 is pi
  localparam int ANGLE_BITS  = 32;
  localparam int ATAN_LEN    = 32;

  localparam int SQ_W        = 2 * DATA_WIDTH;
  localparam int CORDIC_W    = 2 * DATA_WIDTH + 2;
  localparam int ZACC_W      = ANGLE_BITS + 2;

  localparam int ANGLE_SHIFT  = ANGLE_BITS - DATA_WIDTH;
  localparam int ANGLE_HALF   = 1 << (ANGLE_SHIFT - 1);
  localparam int PHASE_PI     = 1 << (DATA_WIDTH - 1);
  localparam int QUARTER_TURN = 1 << (ANGLE_BITS - 2);

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] band_value;
    logic signed [DATA_WIDTH-1:0] riesz_x;
    logic signed [DATA_WIDTH-1:0] riesz_y;
  } mgap_in_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] amplitude;
    logic [DATA_WIDTH-1:0] phase_angle;
  } mgap_out_t;

  // Squared magnitudes, front end to root pipeline
  typedef struct packed {
    logic                         valid;
    logic signed [DATA_WIDTH-1:0] band_value;
    logic [SQ_W-1:0]              rsq;
    logic [SQ_W-1:0]              ssq;
  } mgap_sq_t;

  // Rounded roots, root pipeline to CORDIC
  typedef struct packed {
    logic                         valid;
    logic signed [DATA_WIDTH-1:0] band_value;
    logic [DATA_WIDTH-1:0]        rmag;
    logic [DATA_WIDTH-1:0]        amp;
  } mgap_rt_t;

  // atan(2^-i), 2^31 = pi
  function automatic logic [ANGLE_BITS-1:0] atan_entry(input int idx);
    logic [ANGLE_BITS-1:0] val;
    case (idx)
      0:       val = 32'h20000000;
      1:       val = 32'h12E4051E;
      2:       val = 32'h09FB385B;
      3:       val = 32'h051111D4;
      4:       val = 32'h028B0D43;
      5:       val = 32'h0145D7E1;
      6:       val = 32'h00A2F61E;
      7:       val = 32'h00517C55;
      8:       val = 32'h0028BE53;
      9:       val = 32'h00145F2F;
      10:      val = 32'h000A2F98;
      11:      val = 32'h000517CC;
      12:      val = 32'h00028BE6;
      13:      val = 32'h000145F3;
      14:      val = 32'h0000A2FA;
      15:      val = 32'h0000517D;
      16:      val = 32'h000028BE;
      17:      val = 32'h0000145F;
      18:      val = 32'h00000A30;
      19:      val = 32'h00000518;
      20:      val = 32'h0000028C;
      21:      val = 32'h00000146;
      22:      val = 32'h000000A3;
      23:      val = 32'h00000051;
      24:      val = 32'h00000029;
      25:      val = 32'h00000014;
      26:      val = 32'h0000000A;
      27:      val = 32'h00000005;
      28:      val = 32'h00000003;
      29:      val = 32'h00000001;
      30:      val = 32'h00000001;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

FILE: hdl/monogenic_amplitude_phase_top.sv
// Monogenic local amplitude and phase.
// Request channel: drive in_data (band value h and Riesz components r0, r1,
// signed, 12 fraction bits) and raise start; the request is taken at any
// clock edge with start high and busy low. busy never rises, so a new
// request may be presented every cycle.
// Result channel: out_valid pulses for one cycle with out_data holding the
// amplitude round(sqrt(h^2+r0^2+r1^2)) and the phase atan2(|r|, h) as a
// binary angle (32768 = pi). Results leave in request order.
// From the accepting edge the request passes the square stage, the sum
// stage, 16 square-root steps plus rounding, the -pi/2 pre-rotation,
// one CORDIC rotation per stage and the output rounding/clamp stage.
// Throughput: one request per cycle; every stage is fully pipelined.
// Reset (rst_n low, synchronous) clears all valid bits, dropping anything
// in flight; data registers are not reset.
// The receiver has no back-pressure: results must be taken when shown.
module monogenic_amplitude_phase_top #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mgap_pkg::mgap_in_t  in_data,
  output logic                out_valid,
  output mgap_pkg::mgap_out_t out_data
);

  logic               accept;
  mgap_pkg::mgap_sq_t sq;
  mgap_pkg::mgap_rt_t rt;

  // no stall anywhere in the pipe
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // squares and sums of squares
  mgap_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .sq_o    (sq)
  );

  // two parallel rounded square roots: |r| and the amplitude
  mgap_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .sq_i  (sq),
    .rt_o  (rt)
  );

  // vectoring CORDIC on (h, |r|) gives the phase; amplitude rides along
  mgap_cordic #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .rt_i      (rt),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: hdl/mgap_front.sv
module mgap_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  mgap_pkg::mgap_in_t  in_data,
  output mgap_pkg::mgap_sq_t  sq_o
);

  localparam int DW = mgap_pkg::DATA_WIDTH;
  localparam int SW = mgap_pkg::SQ_W;

  logic signed [SW-1:0] hp_nxt, xp_nxt, yp_nxt;
  logic                 v1_r;
  logic signed [DW-1:0] h1_r;
  logic [SW-2:0]        hsq_r, xsq_r, ysq_r;
  logic [SW-1:0]        rsq_nxt, ssq_nxt;
  mgap_pkg::mgap_sq_t   sq_r;

  assign hp_nxt = in_data.band_value * in_data.band_value;
  assign xp_nxt = in_data.riesz_x * in_data.riesz_x;
  assign yp_nxt = in_data.riesz_y * in_data.riesz_y;

  // squares are at most 2^30, so the top bit is always clear
  always_ff @(posedge clk) begin
    hsq_r <= hp_nxt[SW-2:0];
    xsq_r <= xp_nxt[SW-2:0];
    ysq_r <= yp_nxt[SW-2:0];
    h1_r  <= in_data.band_value;
  end

  assign rsq_nxt = {1'b0, xsq_r} + {1'b0, ysq_r};
  assign ssq_nxt = rsq_nxt + {1'b0, hsq_r};

  always_ff @(posedge clk) begin
    sq_r.band_value <= h1_r;
    sq_r.rsq        <= rsq_nxt;
    sq_r.ssq        <= ssq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      sq_r.valid <= 1'b0;
    end else begin
      v1_r       <= accept;
      sq_r.valid <= v1_r;
    end
  end

  assign sq_o = sq_r;

endmodule

FILE: hdl/mgap_root.sv
module mgap_root (
  input  logic               clk,
  input  logic               rst_n,
  input  mgap_pkg::mgap_sq_t sq_i,
  output mgap_pkg::mgap_rt_t rt_o
);

  localparam int DW = mgap_pkg::DATA_WIDTH;
  localparam int RW = mgap_pkg::SQ_W;
  localparam int NS = RW / 2;

  // one result bit per step: returns {remainder, partial root}
  function automatic logic [2*RW-1:0] root_step(input logic [RW-1:0] rem,
                                                input logic [RW-1:0] res,
                                                input logic [RW-1:0] bitv);
    logic [RW:0] trial;
    trial = {1'b0, res} + {1'b0, bitv};
    if ({1'b0, rem} >= trial) begin
      return {rem - trial[RW-1:0], (res >> 1) + bitv};
    end
    return {rem, res >> 1};
  endfunction

  logic                 vld_r  [0:NS-1];
  logic signed [DW-1:0] h_r    [0:NS-1];
  logic [RW-1:0]        rrem_r [0:NS-1];
  logic [RW-1:0]        rres_r [0:NS-1];
  logic [RW-1:0]        arem_r [0:NS-1];
  logic [RW-1:0]        ares_r [0:NS-1];

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_step
      localparam logic [RW-1:0] STEP_BIT = {{(RW-1){1'b0}}, 1'b1} << (RW - 2 - 2 * k);
      logic                 iv;
      logic signed [DW-1:0] ih;
      logic [RW-1:0]        irrem, irres, iarem, iares;
      logic [2*RW-1:0]      r_nxt, a_nxt;

      if (k == 0) begin : g_first
        assign iv    = sq_i.valid;
        assign ih    = sq_i.band_value;
        assign irrem = sq_i.rsq;
        assign irres = '0;
        assign iarem = sq_i.ssq;
        assign iares = '0;
      end else begin : g_next
        assign iv    = vld_r[k-1];
        assign ih    = h_r[k-1];
        assign irrem = rrem_r[k-1];
        assign irres = rres_r[k-1];
        assign iarem = arem_r[k-1];
        assign iares = ares_r[k-1];
      end

      assign r_nxt = root_step(irrem, irres, STEP_BIT);
      assign a_nxt = root_step(iarem, iares, STEP_BIT);

      always_ff @(posedge clk) begin
        h_r[k]    <= ih;
        rrem_r[k] <= r_nxt[2*RW-1:RW];
        rres_r[k] <= r_nxt[RW-1:0];
        arem_r[k] <= a_nxt[2*RW-1:RW];
        ares_r[k] <= a_nxt[RW-1:0];
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else begin
          vld_r[k] <= iv;
        end
      end
    end
  endgenerate

  // round to nearest: step up when remainder exceeds the floor root
  logic                 rup, aup;
  logic [DW-1:0]        rmag_nxt, amp_nxt;
  mgap_pkg::mgap_rt_t   rt_r;

  assign rup      = rrem_r[NS-1] > rres_r[NS-1];
  assign aup      = arem_r[NS-1] > ares_r[NS-1];
  assign rmag_nxt = rres_r[NS-1][DW-1:0] + {{(DW-1){1'b0}}, rup};
  assign amp_nxt  = ares_r[NS-1][DW-1:0] + {{(DW-1){1'b0}}, aup};

  always_ff @(posedge clk) begin
    rt_r.band_value <= h_r[NS-1];
    rt_r.rmag       <= rmag_nxt;
    rt_r.amp        <= amp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_r.valid <= 1'b0;
    end else begin
      rt_r.valid <= vld_r[NS-1];
    end
  end

  assign rt_o = rt_r;

endmodule

FILE: hdl/mgap_cordic.sv
module mgap_cordic #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mgap_pkg::mgap_rt_t  rt_i,
  output logic                out_valid,
  output mgap_pkg::mgap_out_t out_data
);

  localparam int DW   = mgap_pkg::DATA_WIDTH;
  localparam int CW   = mgap_pkg::CORDIC_W;
  localparam int ZW   = mgap_pkg::ZACC_W;
  localparam int GB   = mgap_pkg::GUARD_BITS;
  localparam int NSTG = (CORDIC_STAGES > mgap_pkg::ATAN_LEN) ?
                        mgap_pkg::ATAN_LEN : CORDIC_STAGES;
  localparam logic signed [ZW-1:0] HALF_Z = ZW'(mgap_pkg::ANGLE_HALF);
  localparam logic signed [ZW-1:0] PI_Z   = ZW'(mgap_pkg::PHASE_PI);
  localparam logic signed [ZW-1:0] QTR_Z  = ZW'(mgap_pkg::QUARTER_TURN);
  localparam logic [DW-1:0]        PI_OUT = DW'(mgap_pkg::PHASE_PI);

  // pre-rotation: left half plane turned by -pi/2
  logic signed [CW-1:0] hx, yr, px_nxt, py_nxt;
  logic signed [ZW-1:0] pz_nxt;
  logic                 neg;
  logic                 pv_r, pzero_r, pneg_r;
  logic signed [CW-1:0] px_r, py_r;
  logic signed [ZW-1:0] pz_r;
  logic [DW-1:0]        pamp_r;

  assign neg    = rt_i.band_value[DW-1];
  assign hx     = CW'(rt_i.band_value) <<< GB;
  assign yr     = CW'({1'b0, rt_i.rmag}) << GB;
  assign px_nxt = neg ? yr : hx;
  assign py_nxt = neg ? -hx : yr;
  assign pz_nxt = neg ? QTR_Z : '0;

  always_ff @(posedge clk) begin
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    pz_r    <= pz_nxt;
    pzero_r <= (rt_i.rmag == '0);
    pneg_r  <= neg;
    pamp_r  <= rt_i.amp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= rt_i.valid;
    end
  end

  logic                 sv_r    [0:NSTG-1];
  logic                 szero_r [0:NSTG-1];
  logic                 sneg_r  [0:NSTG-1];
  logic signed [CW-1:0] sx_r    [0:NSTG-1];
  logic signed [CW-1:0] sy_r    [0:NSTG-1];
  logic signed [ZW-1:0] sz_r    [0:NSTG-1];
  logic [DW-1:0]        samp_r  [0:NSTG-1];

  genvar k;
  generate
    for (k = 0; k < NSTG; k++) begin : g_rot
      localparam logic signed [ZW-1:0] ANG = ZW'(mgap_pkg::atan_entry(k));
      logic                 iv, izero, ineg;
      logic signed [CW-1:0] ix, iy, x_nxt, y_nxt;
      logic signed [ZW-1:0] iz, z_nxt;
      logic [DW-1:0]        iamp;

      if (k == 0) begin : g_first
        assign iv    = pv_r;
        assign izero = pzero_r;
        assign ineg  = pneg_r;
        assign ix    = px_r;
        assign iy    = py_r;
        assign iz    = pz_r;
        assign iamp  = pamp_r;
      end else begin : g_next
        assign iv    = sv_r[k-1];
        assign izero = szero_r[k-1];
        assign ineg  = sneg_r[k-1];
        assign ix    = sx_r[k-1];
        assign iy    = sy_r[k-1];
        assign iz    = sz_r[k-1];
        assign iamp  = samp_r[k-1];
      end

      // drive y toward zero, floor shifts
      always_comb begin
        if (!iy[CW-1]) begin
          x_nxt = ix + (iy >>> k);
          y_nxt = iy - (ix >>> k);
          z_nxt = iz + ANG;
        end else begin
          x_nxt = ix - (iy >>> k);
          y_nxt = iy + (ix >>> k);
          z_nxt = iz - ANG;
        end
      end

      always_ff @(posedge clk) begin
        sx_r[k]    <= x_nxt;
        sy_r[k]    <= y_nxt;
        sz_r[k]    <= z_nxt;
        szero_r[k] <= izero;
        sneg_r[k]  <= ineg;
        samp_r[k]  <= iamp;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          sv_r[k] <= 1'b0;
        end else begin
          sv_r[k] <= iv;
        end
      end
    end
  endgenerate

  // round angle to output scale and clamp to 0..pi; zero |r| gives 0 or pi by the sign of h
  logic signed [ZW-1:0] zr, q;
  logic [DW-1:0]        phase_nxt;
  logic                 out_valid_r;
  mgap_pkg::mgap_out_t  out_r;

  assign zr = sz_r[NSTG-1] + HALF_Z;
  assign q  = zr >>> mgap_pkg::ANGLE_SHIFT;

  always_comb begin
    if (szero_r[NSTG-1]) begin
      phase_nxt = sneg_r[NSTG-1] ? PI_OUT : '0;
    end else if (q < 0) begin
      phase_nxt = '0;
    end else if (q > PI_Z) begin
      phase_nxt = PI_OUT;
    end else begin
      phase_nxt = q[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    out_r.amplitude   <= samp_r[NSTG-1];
    out_r.phase_angle <= phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sv_r[NSTG-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
